### rtl/bavg_pkg.sv
// Shared constants and types for the multichannel block averager.
`timescale 1ns / 1ps

package bavg_pkg;

	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 12;
	localparam int TOTAL_BITS  = SAMPLE_BITS + COUNT_BITS + 1;
	localparam int SCALE_BITS  = 24;
	localparam int LIMIT_BITS  = 12;
	localparam int PROD_BITS   = TOTAL_BITS + SCALE_BITS;
	localparam int QUOT_BITS   = PROD_BITS - SCALE_BITS;
	localparam int DATA_BITS   = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = SCALE_BITS;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(500);
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(33554);

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LIMIT  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_AVERAGE_SCALE = CFG_INDEX_BITS'(1);

	typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_vec_t;
	typedef logic [CHANNELS-1:0][TOTAL_BITS-1:0]  total_vec_t;
	typedef logic [CHANNELS-1:0][PROD_BITS-1:0]   prod_vec_t;

	// Closed window handed from the accumulator to the scaling stages
	typedef struct packed {
		logic       valid;
		total_vec_t totals;
	} snap_t;

endpackage

### rtl/bavg_accum.sv
// Per-channel window accumulator, item counter and closed-window snapshot stage.
`timescale 1ns / 1ps

module bavg_accum (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [bavg_pkg::LIMIT_BITS-1:0]       window_limit,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  bavg_pkg::sample_vec_t                 in_samples,
	output bavg_pkg::snap_t                       snap,
	input  logic                                  snap_ready
);
	import bavg_pkg::*;

	logic [COUNT_BITS-1:0] count_q;
	total_vec_t            totals_q;
	logic                  snap_valid_s1;
	total_vec_t            snap_totals_s1;
	logic                  accept;
	logic                  accumulate;

	assign in_ready   = !snap_valid_s1 || snap_ready;
	assign accept     = in_valid && in_ready;
	assign accumulate = (COUNT_BITS'(count_q) <= COUNT_BITS'(window_limit));

	assign snap.valid  = snap_valid_s1;
	assign snap.totals = snap_totals_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			totals_q      <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			if (snap_ready)
				snap_valid_s1 <= 1'b0;
			if (accept) begin
				if (accumulate) begin
					for (int i = 0; i < CHANNELS; i++)
						totals_q[i] <= totals_q[i] + {{(TOTAL_BITS - SAMPLE_BITS)
							{in_samples[i][SAMPLE_BITS-1]}}, in_samples[i]};
					count_q <= count_q + 1'b1;
				end else begin
					// closing item: its samples are dropped
					totals_q      <= '0;
					count_q       <= '0;
					snap_valid_s1 <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !accumulate)
			snap_totals_s1 <= totals_q;
	end

endmodule

### rtl/bavg_scale.sv
// Scaling multiply, floor shift and saturation stages with the result register.
`timescale 1ns / 1ps

module bavg_scale (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [bavg_pkg::SCALE_BITS-1:0]       average_scale,
	input  bavg_pkg::snap_t                       snap,
	output logic                                  snap_ready,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output bavg_pkg::sample_vec_t                 out_avgs
);
	import bavg_pkg::*;

	logic        valid_s2;
	prod_vec_t   prod_s2;
	logic        valid_s3;
	sample_vec_t avg_s3;
	sample_vec_t sat;
	logic        out_free;
	logic        s2_free;

	assign out_free   = !valid_s3 || out_ready;
	assign s2_free    = !valid_s2 || out_free;
	assign snap_ready = s2_free;
	assign out_valid  = valid_s3;
	assign out_avgs   = avg_s3;

	// Arithmetic shift right then clamp to the sample range
	always_comb begin
		logic [QUOT_BITS-1:0] q;
		sat = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			q = prod_s2[i][PROD_BITS-1:SCALE_BITS];
			if (q[QUOT_BITS-1:SAMPLE_BITS-1] ==
				{(QUOT_BITS - SAMPLE_BITS + 1){q[QUOT_BITS-1]}})
				sat[i] = q[SAMPLE_BITS-1:0];
			else if (q[QUOT_BITS-1])
				sat[i] = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
			else
				sat[i] = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_free)
				valid_s2 <= snap.valid;
			if (out_free)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && snap.valid)
			for (int i = 0; i < CHANNELS; i++)
				prod_s2[i] <= PROD_BITS'($signed(snap.totals[i])
					* $signed({1'b0, average_scale}));
		if (out_free && valid_s2)
			avg_s3 <= sat;
	end

endmodule

### rtl/multichannel_block_averager_core.sv
// Top level of the multichannel block averager: configuration registers and stream ports.
`timescale 1ns / 1ps

// Eight-channel boxcar decimating averager. Every input word carries one signed
// 16-bit sample per channel. While the item count is at or below window_limit the
// samples are added into 29-bit per-channel totals and nothing comes out; the
// next word closes the window instead: its samples are dropped, the totals and
// count are cleared, and one output word follows carrying, per channel,
// (total * average_scale) >> 24 (floor) clamped to the signed 16-bit range.
// A word is accepted every clock while s_axis_tready is high: the accumulate is a
// registered add into the total registers, and a closed window passes a snapshot
// register, a multiply stage and a saturate/output register, in that order, before
// m_axis_tvalid rises. s_axis_tready only drops when those three
// registers are all full and the downstream side is stalling. With window_limit
// at 4095 the count wraps and no output word is ever produced. Write the
// configuration registers only while the block is idle; register index 0 is
// window_limit (12 bits, reset 500), index 1 is average_scale (unsigned Q0.24,
// reset 33554), other indexes are ignored.
module multichannel_block_averager_core (
	input  logic                                    clk,
	input  logic                                    arst_n,

	// configuration write port
	input  logic                                    cfg_we,
	input  logic [bavg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [bavg_pkg::CFG_DATA_BITS-1:0]      cfg_data,

	// sample words in
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// from bit 0: phase_a_current, phase_b_current, phase_c_current, battery_current,
	// line_ab_voltage, line_bc_voltage, line_ca_voltage, battery_voltage
	input  logic [bavg_pkg::DATA_BITS-1:0]          s_axis_tdata,

	// average words out
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// from bit 0: avg_phase_a_current, avg_phase_b_current, avg_phase_c_current,
	// avg_battery_current, avg_line_ab_voltage, avg_line_bc_voltage,
	// avg_line_ca_voltage, avg_battery_voltage
	output logic [bavg_pkg::DATA_BITS-1:0]          m_axis_tdata
);
	import bavg_pkg::*;

	logic [LIMIT_BITS-1:0] window_limit_q;
	logic [SCALE_BITS-1:0] average_scale_q;
	sample_vec_t           in_samples;
	sample_vec_t           out_avgs;
	snap_t                 snap;
	logic                  snap_ready;

	// Hold configuration; only the two listed indexes take effect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_limit_q  <= LIMIT_RESET;
			average_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LIMIT:  window_limit_q  <= cfg_data[LIMIT_BITS-1:0];
				REG_AVERAGE_SCALE: average_scale_q <= cfg_data[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Unpack channels from the word, lowest channel in the lowest bits
	assign in_samples = s_axis_tdata[CHANNELS*SAMPLE_BITS-1:0];

	bavg_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_limit (window_limit_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_samples   (in_samples),
		.snap         (snap),
		.snap_ready   (snap_ready)
	);

	bavg_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.average_scale (average_scale_q),
		.snap          (snap),
		.snap_ready    (snap_ready),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_avgs      (out_avgs)
	);

	// Pad the output word with zeros up to whole bytes
	assign m_axis_tdata = DATA_BITS'(out_avgs);

endmodule
